/* hw/rtl/fsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_pkg
// Types, constants and binary32 arithmetic for the sine/cosine pipeline.
// ----------------------------------------------------------------------------
package fsc_pkg;

   localparam int FSC_STAGES = 18;

   localparam logic [31:0] FSC_D1   = 32'hBF490000;
   localparam logic [31:0] FSC_D2   = 32'hB97DA000;
   localparam logic [31:0] FSC_D3   = 32'hB3222169;
   localparam logic [31:0] FSC_S0   = 32'hB94CA1F9;
   localparam logic [31:0] FSC_S1   = 32'h3C08839E;
   localparam logic [31:0] FSC_S2   = 32'hBE2AAAA3;
   localparam logic [31:0] FSC_C0   = 32'h37CCF5CE;
   localparam logic [31:0] FSC_C1   = 32'hBAB6061A;
   localparam logic [31:0] FSC_C2   = 32'h3D2AAAA5;
   localparam logic [31:0] FSC_FOPI = 32'h3FA2F983;
   localparam logic [31:0] FSC_HALF = 32'h3F000000;
   localparam logic [31:0] FSC_ONE  = 32'h3F800000;
   localparam logic [31:0] FSC_QNAN = 32'hFFC00000;
   localparam logic [31:0] FSC_QBIT = 32'h00400000;
   localparam logic [31:0] FSC_JOVF = 32'h80000000;
   localparam logic [31:0] FSC_NEG2P31 = 32'hCF000000;

   typedef struct packed {
      logic        last;
      logic        sgn;
      logic [31:0] a;
      logic [31:0] j;
      logic [31:0] y;
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] r;
      logic [31:0] z;
      logic [31:0] cp;
      logic [31:0] sp;
   } fsc_item_type;

   function automatic logic fsc_is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic [5:0] fsc_lzc(input logic [49:0] v);
      logic [5:0] lz;
      logic       found;
      lz    = 6'd50;
      found = 1'b0;
      for (int i = 49; i >= 0; i--) begin
         if (!found && v[i]) begin
            lz    = 6'(49 - i);
            found = 1'b1;
         end
      end
      return lz;
   endfunction

   // sig has its binary point after bit 48; value = sig * 2^-48 * 2^(e-127)
   function automatic logic [31:0] fsc_round(input logic sgn, input logic signed [11:0] e,
                                             input logic [49:0] sig);
      logic [5:0]         lz;
      logic [49:0]        sn;
      logic signed [11:0] en;
      logic signed [11:0] diff;
      logic signed [11:0] ebase;
      logic [5:0]         sh;
      logic [99:0]        tmp;
      logic               xst;
      logic [23:0]        m24;
      logic               g;
      logic               st;
      logic               inc;
      logic [32:0]        pre;
      lz  = fsc_lzc(sig);
      sn  = sig << lz;
      en  = e + 12'sd1 - $signed({6'd0, lz});
      xst = 1'b0;
      if (en < 12'sd1) begin
         diff  = 12'sd1 - en;
         sh    = (diff > 12'sd63) ? 6'd63 : diff[5:0];
         tmp   = {sn, 50'd0} >> sh;
         sn    = tmp[99:50];
         xst   = |tmp[49:0];
         ebase = 12'sd0;
      end else begin
         ebase = en - 12'sd1;
      end
      m24 = sn[49:26];
      g   = sn[25];
      st  = (|sn[24:0]) | xst;
      inc = g & (st | m24[0]);
      pre = {ebase[9:0], 23'd0} + {9'd0, m24} + {32'd0, inc};
      if (sig == 50'd0)
         return {sgn, 31'd0};
      else if (pre >= 33'h07F800000)
         return {sgn, 8'hFF, 23'd0};
      else
         return {sgn, pre[30:0]};
   endfunction

   function automatic logic [31:0] fsc_mul(input logic [31:0] a, input logic [31:0] b);
      logic               s;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [47:0]        p;
      logic signed [11:0] e;
      s  = a[31] ^ b[31];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      p  = ma * mb;
      e  = $signed({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]})
         + $signed({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - 12'sd127;
      if (fsc_is_nan(a))
         return a | FSC_QBIT;
      else if (fsc_is_nan(b))
         return b | FSC_QBIT;
      else if (a[30:23] == 8'hFF)
         return (b[30:0] == 31'd0) ? FSC_QNAN : {s, 8'hFF, 23'd0};
      else if (b[30:23] == 8'hFF)
         return (a[30:0] == 31'd0) ? FSC_QNAN : {s, 8'hFF, 23'd0};
      else if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
         return {s, 31'd0};
      else
         return fsc_round(s, e, {p, 2'b00});
   endfunction

   function automatic logic [31:0] fsc_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] lg;
      logic [31:0] sm;
      logic [7:0]  el;
      logic [7:0]  es;
      logic [7:0]  d;
      logic [5:0]  dc;
      logic [49:0] sigl;
      logic [99:0] tmp;
      logic [49:0] sigs;
      logic [49:0] sum;
      logic        s;
      if (a[30:0] >= b[30:0]) begin
         lg = a;
         sm = b;
      end else begin
         lg = b;
         sm = a;
      end
      el   = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
      es   = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
      d    = el - es;
      dc   = (d > 8'd63) ? 6'd63 : d[5:0];
      sigl = {1'b0, lg[30:23] != 8'd0, lg[22:0], 25'd0};
      tmp  = {1'b0, sm[30:23] != 8'd0, sm[22:0], 25'd0, 50'd0} >> dc;
      sigs = tmp[99:50] | {49'd0, |tmp[49:0]};
      if (a[31] == b[31]) begin
         sum = sigl + sigs;
         s   = a[31];
      end else begin
         sum = sigl - sigs;
         s   = lg[31];
      end
      if (fsc_is_nan(a))
         return a | FSC_QBIT;
      else if (fsc_is_nan(b))
         return b | FSC_QBIT;
      else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
         return (a[31] != b[31]) ? FSC_QNAN : a;
      else if (a[30:23] == 8'hFF)
         return a;
      else if (b[30:23] == 8'hFF)
         return b;
      else if (sum == 50'd0)
         return {(a[31] == b[31]) ? a[31] : 1'b0, 31'd0};
      else
         return fsc_round(s, $signed({4'd0, el}), sum);
   endfunction

   function automatic logic [31:0] fsc_sub(input logic [31:0] a, input logic [31:0] b);
      if (fsc_is_nan(a))
         return a | FSC_QBIT;
      else if (fsc_is_nan(b))
         return b | FSC_QBIT;
      else
         return fsc_add(a, {~b[31], b[30:0]});
   endfunction

   // truncate the magnitude to integer; NaN or a positive value of 2^31 or more gives the overflow pattern
   function automatic logic [31:0] fsc_trunc(input logic [31:0] p);
      logic [54:0] tmp;
      tmp = {31'd0, 1'b1, p[22:0]} << (p[30:23] - 8'd127);
      if (fsc_is_nan(p) || (!p[31] && p[30:0] >= 31'h4F000000))
         return FSC_JOVF;
      else if (p[30:23] < 8'd127)
         return 32'd0;
      else
         return tmp[54:23];
   endfunction

   function automatic logic [31:0] fsc_itof(input logic [31:0] j);
      if (j[31])
         return FSC_NEG2P31;
      else
         return fsc_round(1'b0, 12'sd156, {j[30:0], 19'd0});
   endfunction

   function automatic fsc_item_type fsc_step(input logic [4:0] stage, input fsc_item_type i);
      fsc_item_type o;
      logic [31:0]  jn;
      logic [31:0]  jm2;
      logic         ss;
      logic         cs;
      o = i;
      case (stage)
         5'd0: begin
            o.sgn = i.a[31];
            o.a   = {1'b0, i.a[30:0]};
            o.t1  = fsc_mul({1'b0, i.a[30:0]}, FSC_FOPI);
         end
         5'd1: begin
            jn  = fsc_trunc(i.t1);
            jn  = (jn + 32'd1) & ~32'd1;
            o.j = jn;
            o.y = fsc_itof(jn);
         end
         5'd2: o.t1 = fsc_mul(i.y, FSC_D1);
         5'd3: begin
            o.r  = fsc_add(i.a, i.t1);
            o.t2 = fsc_mul(i.y, FSC_D2);
         end
         5'd4: begin
            o.r  = fsc_add(i.r, i.t2);
            o.t1 = fsc_mul(i.y, FSC_D3);
         end
         5'd5: o.r = fsc_add(i.r, i.t1);
         5'd6: o.z = fsc_mul(i.r, i.r);
         5'd7: begin
            o.cp = fsc_mul(FSC_C0, i.z);
            o.sp = fsc_mul(FSC_S0, i.z);
         end
         5'd8: begin
            o.cp = fsc_add(i.cp, FSC_C1);
            o.sp = fsc_add(i.sp, FSC_S1);
         end
         5'd9: begin
            o.cp = fsc_mul(i.cp, i.z);
            o.sp = fsc_mul(i.sp, i.z);
         end
         5'd10: begin
            o.cp = fsc_add(i.cp, FSC_C2);
            o.sp = fsc_add(i.sp, FSC_S2);
         end
         5'd11: begin
            o.cp = fsc_mul(i.cp, i.z);
            o.sp = fsc_mul(i.sp, i.z);
         end
         5'd12: begin
            o.cp = fsc_mul(i.cp, i.z);
            o.sp = fsc_mul(i.sp, i.r);
         end
         5'd13: begin
            o.t1 = fsc_mul(i.z, FSC_HALF);
            o.sp = fsc_add(i.sp, i.r);
         end
         5'd14: o.cp = fsc_sub(i.cp, i.t1);
         5'd15: o.cp = fsc_add(i.cp, FSC_ONE);
         5'd16: begin
            // octant bit 1 clear keeps the sine polynomial for the sine
            o.t1 = i.j[1] ? 32'd0 : i.sp;
            o.t2 = i.j[1] ? i.cp : 32'd0;
            o.sp = fsc_sub(i.sp, i.j[1] ? 32'd0 : i.sp);
            o.cp = fsc_sub(i.cp, i.j[1] ? i.cp : 32'd0);
         end
         5'd17: begin
            jm2  = i.j - 32'd2;
            ss   = i.sgn ^ i.j[2];
            cs   = ~jm2[2];
            o.sp = fsc_add(i.t2, i.t1) ^ {ss, 31'd0};
            o.cp = fsc_add(i.cp, i.sp) ^ {cs, 31'd0};
         end
         default: o = i;
      endcase
      return o;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/float_sine_cosine.sv */
// Pipeline: one register stage per binary32 step of the reduction, the
// polynomials and the final octant select.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// result at its end is not taken.
// Reset: synchronous, clears every stage valid bit; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// float_sine_cosine
// Pipelined single-precision sine and cosine by octant reduction.
// ----------------------------------------------------------------------------
module float_sine_cosine
   import fsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_angle_bits,
   input  wire logic        req_last_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_sine_bits,
   output logic [31:0]      rsp_cosine_bits,
   output logic             rsp_last_out
);

   logic         advance;
   logic         vld [FSC_STAGES+1];
   fsc_item_type itm [FSC_STAGES+1];
   fsc_item_type head_item;

   assign advance = !vld[FSC_STAGES] || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      head_item      = '0;
      head_item.a    = req_angle_bits;
      head_item.last = req_last_in;
   end
   assign itm[0] = head_item;
   assign vld[0] = req_valid;

   for (genvar k = 0; k < FSC_STAGES; k++) begin : g_stage
      fsc_stage #(
         .STAGE(5'(k))
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (vld[k]),
         .in_item  (itm[k]),
         .out_valid(vld[k+1]),
         .out_item (itm[k+1])
      );
   end

   assign rsp_valid       = vld[FSC_STAGES];
   assign rsp_sine_bits   = itm[FSC_STAGES].sp;
   assign rsp_cosine_bits = itm[FSC_STAGES].cp;
   assign rsp_last_out    = itm[FSC_STAGES].last;

endmodule
`default_nettype wire

/* hw/rtl/fsc_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_stage
// One register stage of the pipeline: the step that fsc_step gives for STAGE.
// ----------------------------------------------------------------------------
module fsc_stage
   import fsc_pkg::*;
#(
   parameter logic [4:0] STAGE = 5'd0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         in_valid,
   input  wire fsc_item_type in_item,
   output logic              out_valid,
   output fsc_item_type      out_item
);

   logic         valid_ff;
   fsc_item_type item_ff;
   fsc_item_type item_in;

   assign item_in = fsc_step(STAGE, in_item);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

/* hw/rtl/fsc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_checker
// Port-level checks on the sine/cosine block, bound to the top level.
// ----------------------------------------------------------------------------
module fsc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_sine_bits,
   input wire logic [31:0] rsp_cosine_bits,
   input wire logic        rsp_last_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sine_bits) && $stable(rsp_cosine_bits)
                                  && $stable(rsp_last_out))
      else $error("stalled result changed");

   // input side only stalls when the result at the end is stuck
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind float_sine_cosine fsc_checker u_fsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sine_bits  (rsp_sine_bits),
   .rsp_cosine_bits(rsp_cosine_bits),
   .rsp_last_out   (rsp_last_out)
);
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined binary32 sine/cosine block. Directed
// angles, then random bursts, meet a stalling result port; a bit-exact binary32
// model of the octant reduction predicts both outputs and the last marker.
// ----------------------------------------------------------------------------
module tb_top;
   import fsc_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int RANDOM_ITEMS = 750;
   localparam int DRAIN_CYCLES = 2 * FSC_STAGES;

   typedef struct {
      logic [31:0] sine;
      logic [31:0] cosine;
      logic        last;
   } trig_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_angle_bits = 32'd0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_sine_bits;
   logic [31:0] rsp_cosine_bits;
   logic        rsp_last_out;

   int cycles = 0;

   float_sine_cosine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_angle_bits(req_angle_bits), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sine_bits(rsp_sine_bits), .rsp_cosine_bits(rsp_cosine_bits),
      .rsp_last_out(rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- binary32 arithmetic, round to nearest even ----------------
   function automatic bit fp_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   // value = m * 2^e
   function automatic void fp_split(input logic [31:0] x, output logic [255:0] m,
                                    output int e);
      if (x[30:23] == 8'd0) begin
         m = {233'd0, x[22:0]};
         e = -149;
      end else begin
         m = {232'd0, 1'b1, x[22:0]};
         e = int'(x[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] fp_pack(input bit s, input int e, input logic [255:0] m);
      int          k;
      int          ex;
      int          qexp;
      int          sh;
      logic [255:0] q;
      logic [255:0] rem;
      logic [255:0] half;
      logic [63:0]  bits;
      if (m == 256'd0)
         return {s, 31'd0};
      k = 0;
      for (int i = 0; i < 256; i++)
         if (m[i]) k = i;
      ex   = k + e;
      qexp = (ex - 23 > -149) ? ex - 23 : -149;
      sh   = qexp - e;
      if (sh > 0) begin
         q    = m >> sh;
         rem  = m - (q << sh);
         half = 256'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0]))
            q = q + 256'd1;
      end else begin
         q = m << (-sh);
      end
      // carry out of the mantissa walks into the exponent by itself
      bits = (64'(qexp + 149) << 23) + q[63:0];
      if (bits >= 64'h7F800000)
         return {s, 8'hFF, 23'd0};
      return {s, bits[30:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic [255:0] ma;
      logic [255:0] mb;
      int           ea;
      int           eb;
      bit           s;
      s = a[31] ^ b[31];
      if (fp_nan(a)) return a | FSC_QBIT;
      if (fp_nan(b)) return b | FSC_QBIT;
      if (a[30:23] == 8'hFF) return (b[30:0] == 31'd0) ? FSC_QNAN : {s, 8'hFF, 23'd0};
      if (b[30:23] == 8'hFF) return (a[30:0] == 31'd0) ? FSC_QNAN : {s, 8'hFF, 23'd0};
      fp_split(a, ma, ea);
      fp_split(b, mb, eb);
      return fp_pack(s, ea + eb, ma * mb);
   endfunction

   function automatic logic [255:0] fp_align(input logic [255:0] m, input int e, input int eref);
      logic [255:0] x;
      if (e >= eref)
         return m << (e - eref);
      if (eref - e >= 64)
         return {255'd0, m != 256'd0};
      x = m >> (eref - e);
      if ((x << (eref - e)) != m)
         x[0] = 1'b1;   // sticky
      return x;
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [255:0] ma;
      logic [255:0] mb;
      logic [255:0] xa;
      logic [255:0] xb;
      logic [255:0] sum;
      int           ea;
      int           eb;
      int           eref;
      bit           s;
      if (fp_nan(a)) return a | FSC_QBIT;
      if (fp_nan(b)) return b | FSC_QBIT;
      if (a[30:23] == 8'hFF && b[30:23] == 8'hFF) return (a[31] != b[31]) ? FSC_QNAN : a;
      if (a[30:23] == 8'hFF) return a;
      if (b[30:23] == 8'hFF) return b;
      fp_split(a, ma, ea);
      fp_split(b, mb, eb);
      eref = ((ea > eb) ? ea : eb) - 60;
      xa = fp_align(ma, ea, eref);
      xb = fp_align(mb, eb, eref);
      if (a[31] == b[31]) begin
         sum = xa + xb;
         s   = a[31];
      end else if (xa >= xb) begin
         sum = xa - xb;
         s   = a[31];
      end else begin
         sum = xb - xa;
         s   = b[31];
      end
      if (sum == 256'd0)
         return {(a[31] == b[31]) ? a[31] : 1'b0, 31'd0};
      return fp_pack(s, eref, sum);
   endfunction

   function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
      if (fp_nan(a)) return a | FSC_QBIT;
      if (fp_nan(b)) return b | FSC_QBIT;
      return fp_add(a, {~b[31], b[30:0]});
   endfunction

   function automatic logic [31:0] fp_trunc(input logic [31:0] p);
      logic [255:0] m;
      int           e;
      if (fp_nan(p) || (!p[31] && p[30:0] >= 31'h4F000000))
         return FSC_JOVF;
      fp_split(p, m, e);
      if (e >= 0)
         m = m << e;
      else
         m = m >> (-e);
      return m[31:0];
   endfunction

   function automatic trig_result_type sincos_predict(input logic [31:0] angle,
                                                      input logic last);
      trig_result_type res;
      logic [31:0]  a;
      logic [31:0]  j;
      logic [31:0]  jm2;
      logic [31:0]  y;
      logic [31:0]  r;
      logic [31:0]  z;
      logic [31:0]  cp;
      logic [31:0]  sp;
      logic [31:0]  mask;
      logic [31:0]  sel_s;
      logic [31:0]  sel_c;
      a = {1'b0, angle[30:0]};
      j = fp_trunc(fp_mul(a, FSC_FOPI));
      j = (j + 32'd1) & ~32'd1;
      y = j[31] ? FSC_NEG2P31 : fp_pack(1'b0, 0, {224'd0, j});
      r = fp_add(a, fp_mul(y, FSC_D1));
      r = fp_add(r, fp_mul(y, FSC_D2));
      r = fp_add(r, fp_mul(y, FSC_D3));
      z = fp_mul(r, r);
      cp = fp_add(fp_mul(FSC_C0, z), FSC_C1);
      cp = fp_add(fp_mul(cp, z), FSC_C2);
      cp = fp_mul(fp_mul(cp, z), z);
      cp = fp_add(fp_sub(cp, fp_mul(z, FSC_HALF)), FSC_ONE);
      sp = fp_add(fp_mul(FSC_S0, z), FSC_S1);
      sp = fp_add(fp_mul(sp, z), FSC_S2);
      sp = fp_add(fp_mul(fp_mul(sp, z), r), r);
      // blend by subtraction so zeros and NaNs behave as the float ops give
      mask  = j[1] ? 32'd0 : 32'hFFFFFFFF;
      sel_s = sp & mask;
      sel_c = cp & ~mask;
      sp    = fp_sub(sp, sel_s);
      cp    = fp_sub(cp, sel_c);
      jm2   = j - 32'd2;
      res.sine   = fp_add(sel_c, sel_s) ^ {angle[31] ^ j[2], 31'd0};
      res.cosine = fp_add(cp, sp) ^ {~jm2[2], 31'd0};
      res.last   = last;
      return res;
   endfunction

   // ---------------- scoreboard ----------------
   class sincos_scoreboard;
      trig_result_type due_q[$];
      int              errors = 0;

      function void note_input(input logic [31:0] angle, input logic last);
         due_q.push_back(sincos_predict(angle, last));
      endfunction

      function void check_result(input logic [31:0] sine, input logic [31:0] cosine,
                                 input logic last);
         trig_result_type want;
         if (due_q.size() == 0) begin
            $error("result transaction with nothing outstanding");
            errors++;
            return;
         end
         want = due_q.pop_front();
         if (sine !== want.sine) begin
            $error("sine_bits: expected %h actual %h", want.sine, sine);
            errors++;
         end
         if (cosine !== want.cosine) begin
            $error("cosine_bits: expected %h actual %h", want.cosine, cosine);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_out: expected %b actual %b", want.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return due_q.size();
      endfunction
   endclass

   sincos_scoreboard sb = new();

   // ---------------- sender ----------------
   task automatic send_angle(input logic [31:0] angle, input logic last);
      req_valid      <= 1'b1;
      req_angle_bits <= angle;
      req_last_in    <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_input(angle, last);
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_angle();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v[30:23] = 8'($urandom_range(100, 140));
         5, 6: ;
         7: v[30:23] = 8'($urandom_range(0, 99));
         8: v[30:23] = 8'($urandom_range(141, 254));
         default: begin
            v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 2) == 0) v[22:0] = 23'd0;
         end
      endcase
      return v;
   endfunction

   logic [31:0] directed_angles [] = '{
      32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
      32'h7F800001, 32'hFFBFFFFF, 32'h00000001, 32'h807FFFFF, 32'h00800000,
      32'h7F7FFFFF, 32'hFF7FFFFF, 32'h4EC90FDA, 32'h4EC90FDB, 32'h4EC90FDC,
      32'h3F490FDB, 32'h3FC90FDB, 32'h40490FDB, 32'hC0490FDB, 32'h3F800000,
      32'hBF800000, 32'h47C35000, 32'h40C90FDB, 32'h3A000000, 32'h4B000001
   };

   initial begin
      int sent;
      int burst;
      bit drained;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_angles[i])
         send_angle(directed_angles[i], 1'(i % 2));
      idle_for(3);
      sent    = 0;
      drained = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < RANDOM_ITEMS && (drained || sent != RANDOM_ITEMS / 2)) begin
            send_angle(random_angle(), 1'($urandom_range(0, 1)));
            sent++;
            burst--;
         end
         if (!drained && sent == RANDOM_ITEMS / 2) begin
            // let the pipeline run dry before carrying on
            drained = 1'b1;
            req_valid <= 1'b0;
            while (sb.outstanding() != 0) @(posedge clock);
         end else if ($urandom_range(0, 3) != 0) begin
            idle_for($urandom_range(1, 8));
         end
      end
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("float_sine_cosine: match");
      else
         $display("float_sine_cosine: mismatch");
      $finish;
   end

   // ---------------- receiver ----------------
   initial begin
      int taken;
      int hold_left;
      bit hold_done;
      taken     = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_result(rsp_sine_bits, rsp_cosine_bits, rsp_last_out);
            taken++;
         end
         if (!hold_done && taken == 150) begin
            hold_done = 1'b1;
            hold_left = 300;   // long hold-off so the pipe fills and backs up
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case ((cycles / 256) % 3)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("float_sine_cosine: mismatch");
         $finish;
      end
   end

endmodule
